/* design/rau_pkg.sv */
// Package with opcodes and the controller-datapath command and status types.
package rau_pkg;
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture operands, start products
    logic mul_lo;    // first product pair
    logic mul_hi;    // second product pair
    logic form;      // form numerator and denominator
    logic gcd_init;  // load gcd working registers
    logic gcd_step;  // one gcd iteration
    logic div_init;  // start both divisions
    logic div_step;  // one quotient bit
    logic finish;    // produce the result
  } rau_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic gcd_done;
    logic div_done;
    logic skip;      // no reduction needed for this item
  } rau_sts_t;
endpackage

/* design/rau_datapath.sv */
// Datapath: cross products, binary gcd and restoring dividers.
module rau_datapath #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                clk,
  input  rau_pkg::rau_cmd_t   cmd,
  output rau_pkg::rau_sts_t   sts,
  input  logic [2:0]          in_req_type,
  input  logic signed [31:0]  in_a_num,
  input  logic [30:0]         in_a_den,
  input  logic signed [31:0]  in_b_num,
  input  logic [30:0]         in_b_den,
  output logic signed [63:0]  out_res_num,
  output logic [61:0]         out_res_den,
  output logic                out_is_less,
  output logic                out_is_greater,
  output logic                out_is_equal,
  output logic                out_div_zero
);
  localparam int W = OPERAND_WIDTH;
  localparam int SW = $clog2(65);

  logic [2:0]         op_r;
  logic signed [31:0] an_r, bn_r;
  logic signed [31:0] ad_r, bd_r;
  logic signed [63:0] left_r, right_r, nn_r, dd_r;
  logic               less_r, gre_r, equ_r, dz_r, neg_r;
  logic [63:0]        x_r, y_r, mag_r, den_r;
  logic [SW-1:0]      sh_r;
  logic               xodd_r, gdone_r;
  logic [63:0]        g_r, qn_r, qd_r, rn_r, rd_r;
  logic [6:0]         cnt_r;
  logic signed [63:0] num_w;
  logic [63:0]        den_w;
  logic signed [W-1:0] an_w, bn_w;
  logic [W-2:0]       ad_w, bd_w;
  logic [64:0]        rn_t, rd_t;
  logic [63:0]        ysh;

  // Operand read at the configured width; a zero denominator reads as one.
  always_comb begin
    an_w = in_a_num[W-1:0];
    bn_w = in_b_num[W-1:0];
    ad_w = in_a_den[W-2:0];
    bd_w = in_b_den[W-2:0];
  end

  // Numerator and denominator of the selected operation.
  always_comb begin
    num_w = 64'sd0;
    den_w = 64'd1;
    case (op_r)
      rau_pkg::OP_ADD: begin num_w = left_r + right_r; den_w = dd_r; end
      rau_pkg::OP_SUB: begin num_w = left_r - right_r; den_w = dd_r; end
      rau_pkg::OP_MUL: begin num_w = nn_r; den_w = dd_r; end
      rau_pkg::OP_DIV: begin
        num_w = bn_r[31] ? -left_r : left_r;
        den_w = bn_r[31] ? 64'(-nn_r) : 64'(nn_r);
      end
      default: ;
    endcase
  end

  assign ysh  = y_r[0] ? y_r : (y_r >> 1);
  assign rn_t = {rn_r, qn_r[63]} - {1'b0, g_r};
  assign rd_t = {rd_r, qd_r[63]} - {1'b0, g_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_req_type;
      an_r <= 32'(an_w);
      bn_r <= 32'(bn_w);
      ad_r <= (ad_w == '0) ? 32'sd1 : $signed({{(33-W){1'b0}}, ad_w});
      bd_r <= (bd_w == '0) ? 32'sd1 : $signed({{(33-W){1'b0}}, bd_w});
      dz_r <= 1'b0;
    end
    // Products, one pair a cycle, each 32 by 32.
    if (cmd.mul_lo) begin
      left_r  <= an_r * bd_r;
      right_r <= bn_r * ad_r;
    end
    if (cmd.mul_hi) begin
      dd_r   <= ad_r * bd_r;
      nn_r   <= (op_r == rau_pkg::OP_DIV) ? ad_r * bn_r : an_r * bn_r;
      less_r <= left_r < right_r;
      gre_r  <= left_r > right_r;
      equ_r  <= left_r == right_r;
      dz_r   <= (op_r == rau_pkg::OP_DIV) && (bn_r == 32'sd0);
    end
    if (cmd.form) begin
      neg_r <= num_w < 0;
      mag_r <= (num_w < 0) ? 64'(-num_w) : 64'(num_w);
      den_r <= den_w;
    end
    // Binary gcd, one shift or subtract a cycle.
    if (cmd.gcd_init) begin
      x_r <= mag_r; y_r <= den_r; sh_r <= '0; xodd_r <= 1'b0; gdone_r <= 1'b0;
    end else if (cmd.gcd_step && !gdone_r) begin
      if (x_r == 64'd0) begin
        // A zero numerator is reduced by the denominator itself.
        gdone_r <= 1'b1;
        g_r <= y_r;
      end else if (!xodd_r) begin
        if (x_r[0] == 1'b0 && y_r[0] == 1'b0) begin
          x_r <= x_r >> 1; y_r <= y_r >> 1; sh_r <= sh_r + 1'b1;
        end else if (x_r[0] == 1'b0) x_r <= x_r >> 1;
        else xodd_r <= 1'b1;
      end else if (y_r == 64'd0) begin
        gdone_r <= 1'b1;
        g_r <= x_r << sh_r;
      end else if (!y_r[0]) y_r <= ysh;
      else if (x_r > y_r) begin x_r <= y_r; y_r <= x_r - y_r; end
      else y_r <= y_r - x_r;
    end
    // Two restoring dividers by the gcd, one quotient bit a cycle.
    if (cmd.div_init) begin
      qn_r <= mag_r; qd_r <= den_r; rn_r <= '0; rd_r <= '0; cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + 1'b1;
      if (!rn_t[64]) begin rn_r <= rn_t[63:0]; qn_r <= {qn_r[62:0], 1'b1}; end
      else begin rn_r <= {rn_r[62:0], qn_r[63]}; qn_r <= {qn_r[62:0], 1'b0}; end
      if (!rd_t[64]) begin rd_r <= rd_t[63:0]; qd_r <= {qd_r[62:0], 1'b1}; end
      else begin rd_r <= {rd_r[62:0], qd_r[63]}; qd_r <= {qd_r[62:0], 1'b0}; end
    end
    if (cmd.finish) begin
      out_is_less    <= less_r;
      out_is_greater <= gre_r;
      out_is_equal   <= equ_r;
      out_div_zero   <= dz_r;
      if (sts.skip) begin
        out_res_num <= 64'sd0;
        out_res_den <= 62'd1;
      end else begin
        out_res_num <= neg_r ? -$signed(qn_r) : $signed(qn_r);
        out_res_den <= qd_r[61:0];
      end
    end
  end

  assign sts.gcd_done = gdone_r;
  assign sts.div_done = (cnt_r == 7'd63) && cmd.div_step;
  assign sts.skip     = dz_r || !(op_r == rau_pkg::OP_ADD || op_r == rau_pkg::OP_SUB ||
                                  op_r == rau_pkg::OP_MUL || op_r == rau_pkg::OP_DIV);
endmodule

/* design/rau_ctrl.sv */
// Controller state machine sequencing products, gcd and divisions.
module rau_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  output rau_pkg::rau_cmd_t cmd,
  input  rau_pkg::rau_sts_t sts
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MLO  = 3'd1;
  localparam logic [2:0] S_MHI  = 3'd2;
  localparam logic [2:0] S_FORM = 3'd3;
  localparam logic [2:0] S_GCD  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       valid_r;
  logic       ginit_r;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = start;
        if (start) state_nxt = S_MLO;
      end
      S_MLO: begin cmd.mul_lo = 1'b1; state_nxt = S_MHI; end
      S_MHI: begin cmd.mul_hi = 1'b1; state_nxt = S_FORM; end
      S_FORM: begin
        cmd.form = 1'b1;
        state_nxt = sts.skip ? S_FIN : S_GCD;
      end
      // The first gcd cycle loads the working registers, so the done flag is stale then.
      S_GCD: begin
        cmd.gcd_init = ginit_r;
        cmd.gcd_step = !ginit_r;
        if (!ginit_r && sts.gcd_done) begin cmd.div_init = 1'b1; state_nxt = S_DIV; end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_FIN;
      end
      S_FIN: begin cmd.finish = 1'b1; state_nxt = S_IDLE; end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The gcd registers load in the cycle after the magnitudes form.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
      ginit_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= cmd.finish;
      ginit_r <= (state_r == S_FORM) && !sts.skip;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = valid_r;
endmodule

/* design/rational_arithmetic_unit.sv */
// Top level: rational add, subtract, multiply, divide and compare with gcd reduction.
// An accepted item runs the product pairs, forming, the binary gcd, whose steps vary with
// the operands, and the bit-serial divisions; then out_valid rises with the result.
// Spare codes and divide by zero skip reduction; the compare flags come with every result.
// One item at a time: busy falls as the result strobe rises. rst_n, synchronous and active
// low, clears the controller; the receiver cannot stall results.
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_req_type,
  input  logic signed [31:0] in_a_num,
  input  logic [30:0]        in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic [30:0]        in_b_den,
  output logic               out_valid,
  output logic signed [63:0] out_res_num,
  output logic [61:0]        out_res_den,
  output logic               out_is_less,
  output logic               out_is_greater,
  output logic               out_is_equal,
  output logic               out_div_zero
);
  rau_pkg::rau_cmd_t cmd;
  rau_pkg::rau_sts_t sts;

  rau_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .out_valid(out_valid), .cmd(cmd), .sts(sts)
  );

  rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
    .clk(clk), .cmd(cmd), .sts(sts),
    .in_req_type(in_req_type), .in_a_num(in_a_num), .in_a_den(in_a_den),
    .in_b_num(in_b_num), .in_b_den(in_b_den),
    .out_res_num(out_res_num), .out_res_den(out_res_den),
    .out_is_less(out_is_less), .out_is_greater(out_is_greater),
    .out_is_equal(out_is_equal), .out_div_zero(out_div_zero)
  );
endmodule
